// ===== rtl/bqe_pkg.sv =====
package bqe_pkg;

    // Queue between the setup pipeline and the vertex sequencer
    localparam int BQE_QUEUE_DEPTH = 2;

    // Six corners per particle, two triangles
    localparam int CORNERS = 6;
    typedef logic [2:0] corner_idx_t;
    localparam corner_idx_t LAST_CORNER = corner_idx_t'(CORNERS - 1);

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_CAM_UP_X    = 3'd0;
    localparam cfg_idx_t REG_CAM_UP_Y    = 3'd1;
    localparam cfg_idx_t REG_CAM_UP_Z    = 3'd2;
    localparam cfg_idx_t REG_CAM_RIGHT_X = 3'd3;
    localparam cfg_idx_t REG_CAM_RIGHT_Y = 3'd4;
    localparam cfg_idx_t REG_CAM_RIGHT_Z = 3'd5;

    // Q1.14 one, used for the reset camera basis
    localparam logic signed [15:0] CAM_ONE = 16'sd16384;

    // Fixed-point widths: Q1.14 products, size-scaled sum, rounding to Q8.8
    localparam int PROD_W    = 32;
    localparam int DIFF_W    = PROD_W + 1;
    localparam int SCALE_W   = DIFF_W + 13;
    localparam int FRAC_DROP = 28;
    localparam int AXIS_W    = 17;
    localparam logic signed [SCALE_W-1:0] ROUND_HALF = SCALE_W'(64'sd1 <<< (FRAC_DROP - 1));

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic signed [15:0]       coord_t;
    typedef logic signed [AXIS_W-1:0] axis_t;

    // Corner axis selection
    typedef enum logic [1:0] {
        AX_UP_POS = 2'd0,
        AX_RT_POS = 2'd1,
        AX_UP_NEG = 2'd2,
        AX_RT_NEG = 2'd3
    } axis_sel_t;

    // Corner order +Up, +Right, -Up, -Up, -Right, +Up
    localparam axis_sel_t CORNER_AXIS [CORNERS] = '{
        AX_UP_POS, AX_RT_POS, AX_UP_NEG, AX_UP_NEG, AX_RT_NEG, AX_UP_POS
    };
    // Texture corners, bit k for corner k
    localparam logic [CORNERS-1:0] CORNER_U = 6'b100011;
    localparam logic [CORNERS-1:0] CORNER_V = 6'b001110;

    // Input item: one particle
    typedef struct packed {
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [15:0] org_z;
        logic [11:0] half_size;
        logic [15:0] sine;
        logic [15:0] cosine;
        logic [16:0] age;
        logic        batch_end;
    } bqe_particle_t;

    // Result item: one vertex
    typedef struct packed {
        logic [15:0] vert_x;
        logic [15:0] vert_y;
        logic [15:0] vert_z;
        logic [31:0] diffuse;
        logic        tex_u;
        logic        tex_v;
        logic        last_vertex;
        logic        batch_done;
    } bqe_vertex_t;

    // Set-up quad handed from front to back
    typedef struct packed {
        coord_t     org_x;
        coord_t     org_y;
        coord_t     org_z;
        axis_t      up_x;
        axis_t      up_y;
        axis_t      up_z;
        axis_t      rt_x;
        axis_t      rt_y;
        axis_t      rt_z;
        logic [7:0] shade;
        logic       batch_end;
    } bqe_quad_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic avail;
    } bqe_qstat_t;

endpackage

// ===== rtl/billboard_quad_expander.sv =====
// Channel   Direction  Handshake          Item
// -------   ---------  ---------          ----
// s_        in         s_valid / s_ready  one particle (bqe_particle_t)
// m_        out        m_valid / m_ready  one vertex (bqe_vertex_t), six per particle
// cfg_      in         cfg_wr_en          camera basis register write, no wait
//
// A particle passes through the setup pipeline (products, rotation, size scaling)
// before rounding into the quad queue; its first vertex is loaded from the queue
// head into the output register. Sustained rate is set by the single vertex output
// register, emitting one corner per cycle while m_ready is high and a quad is queued.
// Reset loads the default camera basis and empties the queue and output stage.
// m_ready low holds the output register; s_ready drops while a quad waits on a full queue.
module billboard_quad_expander #(
    parameter int QUEUE_DEPTH = bqe_pkg::BQE_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bqe_pkg::bqe_particle_t s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bqe_pkg::bqe_vertex_t   m_data
);
    import bqe_pkg::*;

    bqe_qstat_t q_stat;
    bqe_quad_t  q_push_data;
    bqe_quad_t  q_head;
    logic       q_push;
    logic       q_pop;

    // setup pipeline
    bqe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // quad queue
    bqe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    // vertex sequencer
    bqe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .head    (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // batch marker only on a quad's closing vertex
    a_batch_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.batch_done |-> m_data.last_vertex)
        else $error("batch_done without last_vertex");

    // input stalls only on a full queue
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_stat.full)
        else $error("input stalled with room in queue");

    // the rest of a quad follows without a gap
    a_quad_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_vertex |=> m_valid)
        else $error("gap inside a quad");

    // retiring a quad shows its closing vertex next
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid && m_data.last_vertex)
        else $error("quad retired before its last vertex");

endmodule

// ===== rtl/bqe_front.sv =====
module bqe_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bqe_pkg::bqe_particle_t s_data,
    input  bqe_pkg::bqe_qstat_t    q_stat,
    output logic                   q_push,
    output bqe_pkg::bqe_quad_t     q_push_data
);
    import bqe_pkg::*;

    coord_t cam_up_reg [3];
    coord_t cam_rt_reg [3];

    logic v1_reg, v2_reg, v3_reg;
    logic ce;

    // stage 1: products
    logic signed [PROD_W-1:0] p_uc_reg [3];
    logic signed [PROD_W-1:0] p_rs_reg [3];
    logic signed [PROD_W-1:0] p_rc_reg [3];
    logic signed [PROD_W-1:0] p_us_reg [3];
    coord_t      org1_reg [3];
    logic [11:0] size1_reg;
    logic [7:0]  shade1_reg;
    logic        bend1_reg;

    // stage 2: rotated basis
    logic signed [DIFF_W-1:0] d_up_reg [3];
    logic signed [DIFF_W-1:0] d_rt_reg [3];
    coord_t      org2_reg [3];
    logic [11:0] size2_reg;
    logic [7:0]  shade2_reg;
    logic        bend2_reg;

    // stage 3: scaled by size
    logic signed [SCALE_W-1:0] s_up_reg [3];
    logic signed [SCALE_W-1:0] s_rt_reg [3];
    coord_t      org3_reg [3];
    logic [7:0]  shade3_reg;
    logic        bend3_reg;

    coord_t      org_in [3];
    logic [15:0] ramp_t;
    logic [24:0] ramp_prod;
    logic [7:0]  shade_c;
    logic signed [SCALE_W-1:0] r_up [3];
    logic signed [SCALE_W-1:0] r_rt [3];

    // camera basis registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_up_reg[0] <= '0;
            cam_up_reg[1] <= CAM_ONE;
            cam_up_reg[2] <= '0;
            cam_rt_reg[0] <= CAM_ONE;
            cam_rt_reg[1] <= '0;
            cam_rt_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAM_UP_X:    cam_up_reg[0] <= cfg_wdata;
                REG_CAM_UP_Y:    cam_up_reg[1] <= cfg_wdata;
                REG_CAM_UP_Z:    cam_up_reg[2] <= cfg_wdata;
                REG_CAM_RIGHT_X: cam_rt_reg[0] <= cfg_wdata;
                REG_CAM_RIGHT_Y: cam_rt_reg[1] <= cfg_wdata;
                REG_CAM_RIGHT_Z: cam_rt_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipeline holds while the last stage waits on a full queue
    assign ce      = !(v3_reg && q_stat.full);
    assign s_ready = ce;
    assign q_push  = v3_reg && !q_stat.full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign org_in[0] = s_data.org_x;
    assign org_in[1] = s_data.org_y;
    assign org_in[2] = s_data.org_z;

    // age ramp: up to 255 at half age, zero at or past either end
    always_comb begin
        if (s_data.age[16] || (s_data.age == '0)) begin
            ramp_t = '0;
        end else if (s_data.age <= 17'd32768) begin
            ramp_t = s_data.age[15:0];
        end else begin
            ramp_t = 16'(17'd65536 - s_data.age);
        end
        ramp_prod = 25'(ramp_t) * 25'd510;
        shade_c   = (ramp_prod[24:16] > 9'd255) ? 8'd255 : ramp_prod[23:16];
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                p_uc_reg[i] <= cam_up_reg[i] * $signed(s_data.cosine);
                p_rs_reg[i] <= cam_rt_reg[i] * $signed(s_data.sine);
                p_rc_reg[i] <= cam_rt_reg[i] * $signed(s_data.cosine);
                p_us_reg[i] <= cam_up_reg[i] * $signed(s_data.sine);
                org1_reg[i] <= org_in[i];
            end
            size1_reg  <= s_data.half_size;
            shade1_reg <= shade_c;
            bend1_reg  <= s_data.batch_end;
        end
    end

    // stage 2
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                d_up_reg[i] <= DIFF_W'(p_uc_reg[i]) - DIFF_W'(p_rs_reg[i]);
                d_rt_reg[i] <= DIFF_W'(p_rc_reg[i]) + DIFF_W'(p_us_reg[i]);
                org2_reg[i] <= org1_reg[i];
            end
            size2_reg  <= size1_reg;
            shade2_reg <= shade1_reg;
            bend2_reg  <= bend1_reg;
        end
    end

    // stage 3
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s_up_reg[i] <= d_up_reg[i] * $signed({1'b0, size2_reg});
                s_rt_reg[i] <= d_rt_reg[i] * $signed({1'b0, size2_reg});
                org3_reg[i] <= org2_reg[i];
            end
            shade3_reg <= shade2_reg;
            bend3_reg  <= bend2_reg;
        end
    end

    // round to Q8.8, halves toward plus infinity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r_up[i] = s_up_reg[i] + ROUND_HALF;
            r_rt[i] = s_rt_reg[i] + ROUND_HALF;
        end
    end

    assign q_push_data.org_x     = org3_reg[0];
    assign q_push_data.org_y     = org3_reg[1];
    assign q_push_data.org_z     = org3_reg[2];
    assign q_push_data.up_x      = r_up[0][FRAC_DROP+AXIS_W-1:FRAC_DROP];
    assign q_push_data.up_y      = r_up[1][FRAC_DROP+AXIS_W-1:FRAC_DROP];
    assign q_push_data.up_z      = r_up[2][FRAC_DROP+AXIS_W-1:FRAC_DROP];
    assign q_push_data.rt_x      = r_rt[0][FRAC_DROP+AXIS_W-1:FRAC_DROP];
    assign q_push_data.rt_y      = r_rt[1][FRAC_DROP+AXIS_W-1:FRAC_DROP];
    assign q_push_data.rt_z      = r_rt[2][FRAC_DROP+AXIS_W-1:FRAC_DROP];
    assign q_push_data.shade     = shade3_reg;
    assign q_push_data.batch_end = bend3_reg;

endmodule

// ===== rtl/bqe_queue.sv =====
module bqe_queue #(
    parameter int DEPTH = bqe_pkg::BQE_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bqe_pkg::bqe_quad_t  push_data,
    input  logic                pop,
    output bqe_pkg::bqe_quad_t  head,
    output bqe_pkg::bqe_qstat_t q_stat
);
    import bqe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bqe_quad_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.avail = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.avail;
    assign head         = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bqe_back.sv =====
module bqe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bqe_pkg::bqe_qstat_t  q_stat,
    input  bqe_pkg::bqe_quad_t   head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bqe_pkg::bqe_vertex_t m_data
);
    import bqe_pkg::*;

    corner_idx_t k_reg;
    logic        m_valid_reg;
    bqe_vertex_t m_data_reg;
    bqe_vertex_t vert_next;
    logic        load;
    axis_sel_t   sel;
    logic        use_up, negate;

    coord_t            org [3];
    axis_t             up [3];
    axis_t             rt [3];
    axis_t             comp [3];
    logic signed [17:0] sum [3];
    coord_t            sat [3];

    // output register takes a vertex whenever a quad is queued and it is empty or being taken
    assign load  = q_stat.avail && (!m_valid_reg || m_ready);
    assign q_pop = load && (k_reg == LAST_CORNER);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            k_reg       <= (k_reg == LAST_CORNER) ? '0 : k_reg + 1'b1;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign org[0] = head.org_x;
    assign org[1] = head.org_y;
    assign org[2] = head.org_z;
    assign up[0]  = head.up_x;
    assign up[1]  = head.up_y;
    assign up[2]  = head.up_z;
    assign rt[0]  = head.rt_x;
    assign rt[1]  = head.rt_y;
    assign rt[2]  = head.rt_z;

    // corner decode
    assign sel = CORNER_AXIS[k_reg];
    always_comb begin
        unique case (sel)
            AX_UP_POS: begin use_up = 1'b1; negate = 1'b0; end
            AX_RT_POS: begin use_up = 1'b0; negate = 1'b0; end
            AX_UP_NEG: begin use_up = 1'b1; negate = 1'b1; end
            AX_RT_NEG: begin use_up = 1'b0; negate = 1'b1; end
            default:   begin use_up = 1'b1; negate = 1'b0; end
        endcase
    end

    // corner position with saturation to Q7.8
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comp[i] = use_up ? up[i] : rt[i];
            sum[i]  = negate ? (18'(org[i]) - 18'(comp[i])) : (18'(org[i]) + 18'(comp[i]));
            if (sum[i] > 18'sd32767) begin
                sat[i] = 16'sh7FFF;
            end else if (sum[i] < -18'sd32768) begin
                sat[i] = 16'sh8000;
            end else begin
                sat[i] = sum[i][15:0];
            end
        end
    end

    always_comb begin
        vert_next.vert_x      = sat[0];
        vert_next.vert_y      = sat[1];
        vert_next.vert_z      = sat[2];
        vert_next.diffuse     = {ALPHA_OPAQUE, head.shade, head.shade, head.shade};
        vert_next.tex_u       = CORNER_U[k_reg];
        vert_next.tex_v       = CORNER_V[k_reg];
        vert_next.last_vertex = (k_reg == LAST_CORNER);
        vert_next.batch_done  = (k_reg == LAST_CORNER) && head.batch_end;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= vert_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
